// ===== design/gouraud_span_alpha_blender_top_defines.svh =====
// assertion macros shared by the span blender modules
// no dependencies; each macro compiles to nothing when SYNTHESIS is defined
`ifndef GOURAUD_SPAN_ALPHA_BLENDER_TOP_DEFINES_SVH
`define GOURAUD_SPAN_ALPHA_BLENDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds on every clock edge outside reset
`define GSAB_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");
// antecedent implies consequent on the same edge
`define GSAB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent on the next edge
`define GSAB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GSAB_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define GSAB_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define GSAB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/gsab_pkg.sv =====
// types and constants of the gouraud span alpha blender
// no dependencies
package gsab_pkg;

    localparam int NUM_CH = 4;          // red, green, blue, alpha
    localparam int ACC_W  = 17;
    localparam int STEP_W = 18;
    localparam int LANE_W = 8;
    localparam int PIX_W  = 32;

    localparam logic [ACC_W-1:0] ACC_MAX = 17'h10000;
    localparam int CH_ALPHA = 3;

    typedef logic [ACC_W-1:0]         t_acc;
    typedef logic signed [STEP_W-1:0] t_step;
    typedef logic [PIX_W-1:0]         t_pixel;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    // one pixel of work handed from the front to the back
    typedef struct packed {
        t_pixel dst;
        t_pixel src;
        logic   blend;
    } t_work;

endpackage

// ===== design/gouraud_span_alpha_blender_top.sv =====
// Gouraud span shader with alpha blending over the destination pixel.
// A load item (cmd 0) sets the red, green, blue and alpha 1.16 accumulators
// and their signed steps and gives no result; a pixel item (cmd 1) gives one
// result, the packed interpolated colour, its blend over dest_pixel or, in
// blend mode with zero alpha, dest_pixel unwritten, after which the
// accumulators step and saturate to 0..0x10000. A stream runs at one item
// per clock while the work queue has room. An accepted pixel is written into
// a work queue of QUEUE_DEPTH entries; when the back pops it, it is mixed and
// loaded into the output register. The input stalls only when that queue is
// full; queue and output register hold QUEUE_DEPTH + 1 pixels between them,
// so a steady stream stalls its input once the output side has held off
// until both are full. The blend_enable register resets to 1 and is written
// through the configuration channel, which is always ready.
// depends on gsab_pkg, gsab_front, gsab_queue and gsab_back
module gouraud_span_alpha_blender_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_cmd,
    input  logic [31:0]  i_dest_pixel,
    input  logic [16:0]  i_red_start,
    input  logic [16:0]  i_green_start,
    input  logic [16:0]  i_blue_start,
    input  logic [16:0]  i_alpha_start,
    input  logic signed [17:0] i_red_step,
    input  logic signed [17:0] i_green_step,
    input  logic signed [17:0] i_blue_step,
    input  logic signed [17:0] i_alpha_step,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [31:0]  o_pixel_out,
    output logic         o_write_pixel
);
    import gsab_pkg::*;

    t_acc   w_start [NUM_CH];
    t_step  w_step  [NUM_CH];
    logic   w_full;
    logic   w_push;
    t_work  w_in_work;
    logic   w_pop;
    logic   w_empty;
    t_work  w_out_work;

    assign w_start[0] = i_red_start;
    assign w_start[1] = i_green_start;
    assign w_start[2] = i_blue_start;
    assign w_start[3] = i_alpha_start;
    assign w_step[0]  = i_red_step;
    assign w_step[1]  = i_green_step;
    assign w_step[2]  = i_blue_step;
    assign w_step[3]  = i_alpha_step;

    gsab_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_dest_pixel (i_dest_pixel),
        .i_start      (w_start),
        .i_step       (w_step),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_work       (w_in_work)
    );

    gsab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_work),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_out_work),
        .o_empty (w_empty)
    );

    gsab_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_work        (w_out_work),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_out   (o_pixel_out),
        .o_write_pixel (o_write_pixel)
    );

endmodule

// ===== design/gsab_front.sv =====
// front part: span state, load decoding, source colour and accumulator stepping
// depends on gsab_pkg and the assertion macro header
`include "gouraud_span_alpha_blender_top_defines.svh"

module gsab_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  gsab_pkg::t_pixel      i_dest_pixel,
    input  gsab_pkg::t_acc        i_start [gsab_pkg::NUM_CH],
    input  gsab_pkg::t_step       i_step  [gsab_pkg::NUM_CH],
    input  logic                  i_queue_full,
    output logic                  o_push,
    output gsab_pkg::t_work       o_work
);
    import gsab_pkg::*;

    t_acc  r_acc  [NUM_CH];
    t_acc  n_acc  [NUM_CH];
    t_step r_step [NUM_CH];
    t_step n_step [NUM_CH];
    logic  r_blend;
    logic  n_blend;

    logic  w_accept;
    logic  [LANE_W-1:0] w_lane [NUM_CH];
    logic  signed [STEP_W:0] w_sum [NUM_CH];

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_queue_full;
    assign w_accept    = i_valid && o_ready;

    // full intensity reads as 0xff instead of wrapping
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            w_lane[k] = r_acc[k][ACC_W-1] ? {LANE_W{1'b1}} : r_acc[k][15:8];
            w_sum[k]  = $signed({2'b00, r_acc[k]}) + $signed({r_step[k][STEP_W-1], r_step[k]});
        end
    end

    always_comb begin
        o_push       = w_accept && (t_cmd'(i_cmd) == CMD_PIXEL);
        o_work.dst   = i_dest_pixel;
        o_work.src   = {w_lane[3], w_lane[2], w_lane[1], w_lane[0]};
        o_work.blend = r_blend;
    end

    always_comb begin
        n_blend = r_blend;
        if (i_cfg_valid && o_cfg_ready) begin
            n_blend = i_cfg_data;
        end
        for (int k = 0; k < NUM_CH; k++) begin
            n_acc[k]  = r_acc[k];
            n_step[k] = r_step[k];
            if (w_accept) begin
                unique case (t_cmd'(i_cmd))
                    CMD_LOAD: begin
                        n_acc[k]  = (i_start[k] > ACC_MAX) ? ACC_MAX : i_start[k];
                        n_step[k] = i_step[k];
                    end
                    CMD_PIXEL: begin
                        // saturate the stepped value to 0..ACC_MAX
                        if (w_sum[k][STEP_W]) begin
                            n_acc[k] = '0;
                        end else if (w_sum[k] > $signed({2'b00, ACC_MAX})) begin
                            n_acc[k] = ACC_MAX;
                        end else begin
                            n_acc[k] = w_sum[k][ACC_W-1:0];
                        end
                    end
                    default: begin
                        n_acc[k] = r_acc[k];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= 1'b1;
            for (int k = 0; k < NUM_CH; k++) begin
                r_acc[k]  <= '0;
                r_step[k] <= '0;
            end
        end else begin
            r_blend <= n_blend;
            for (int k = 0; k < NUM_CH; k++) begin
                r_acc[k]  <= n_acc[k];
                r_step[k] <= n_step[k];
            end
        end
    end

    `GSAB_ASSERT_ALWAYS(a_acc_lo, i_clk, i_rst_n, (r_acc[0] <= ACC_MAX) && (r_acc[1] <= ACC_MAX))
    `GSAB_ASSERT_ALWAYS(a_acc_hi, i_clk, i_rst_n, (r_acc[2] <= ACC_MAX) && (r_acc[3] <= ACC_MAX))
    `GSAB_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, o_push, !i_queue_full)

endmodule

// ===== design/gsab_queue.sv =====
// short register queue of pixel work between the front and the back
// depends on gsab_pkg and the assertion macro header
`include "gouraud_span_alpha_blender_top_defines.svh"

module gsab_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gsab_pkg::t_work   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output gsab_pkg::t_work   o_data,
    output logic              o_empty
);
    import gsab_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_work             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `GSAB_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= FULL_CNT)
    `GSAB_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, !o_empty)
    `GSAB_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ===== design/gsab_back.sv =====
// back part: per-lane alpha mix and the registered result stage
// depends on gsab_pkg
module gsab_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsab_pkg::t_work   i_work,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output gsab_pkg::t_pixel  o_pixel_out,
    output logic              o_write_pixel
);
    import gsab_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_pixel            r_pixel;
    t_pixel            n_pixel;
    logic              r_write;
    logic              n_write;

    logic [LANE_W-1:0] w_alpha;
    logic [LANE_W:0]   w_inv;
    logic [15:0]       w_mix [NUM_CH];
    t_pixel            w_blend;

    assign w_alpha = i_work.src[CH_ALPHA*LANE_W +: LANE_W];
    assign w_inv   = 9'h100 - {1'b0, w_alpha};

    // each lane stays below 0x10000, so lanes never carry into each other
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            w_mix[k] = 16'(i_work.src[k*LANE_W +: LANE_W]) * 16'(w_alpha)
                     + 16'(i_work.dst[k*LANE_W +: LANE_W]) * 16'(w_inv);
            w_blend[k*LANE_W +: LANE_W] = w_mix[k][15:8];
        end
    end

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        n_pixel = r_pixel;
        n_write = r_write;
        if (o_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (o_pop) begin
            n_valid = 1'b1;
            priority if (!i_work.blend) begin
                n_pixel = i_work.src;
                n_write = 1'b1;
            end else if (w_alpha == '0) begin
                // transparent source leaves the destination alone
                n_pixel = i_work.dst;
                n_write = 1'b0;
            end else begin
                n_pixel = w_blend;
                n_write = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_pixel;
        r_write <= n_write;
    end

    assign o_valid       = r_valid;
    assign o_pixel_out   = r_pixel;
    assign o_write_pixel = r_write;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for gouraud_span_alpha_blender_top
// depends on gsab_pkg; a scoreboard class shades each accepted item and checks the results
module testbench;
    import gsab_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int LONG_HOLD    = 64;
    localparam int SETTLE_EDGES = 4;     // a load in flight gives no result to wait for

    typedef struct {
        t_cmd   cmd;
        t_pixel dest;
        t_acc   start [4];
        t_step  incr [4];
    } span_item_t;

    typedef struct {
        t_pixel pixel;
        bit     wr_en;
    } shade_result_t;

    class blend_scoreboard;
        localparam bit [31:0] LANE_HI = 32'hff00ff00;
        localparam bit [31:0] LANE_LO = 32'h00ff00ff;

        int acc [4];
        int incr [4];
        bit blend_on;
        shade_result_t awaited_pixels [$];
        int errors, loads, blended, copied, skipped;

        function new();
            foreach (acc[i]) begin
                acc[i] = 0;
                incr[i] = 0;
            end
            blend_on = 1'b1;
        endfunction

        function void set_blend(bit v);
            blend_on = v;
        endfunction

        function int outstanding();
            return awaited_pixels.size();
        endfunction

        function bit [7:0] lane_byte(int a);
            if (a >= int'(ACC_MAX)) return 8'hff;
            if (a <= 0) return 8'h00;
            return a[15:8];
        endfunction

        function int clamp_acc(int v);
            if (v < 0) return 0;
            if (v > int'(ACC_MAX)) return int'(ACC_MAX);
            return v;
        endfunction

        // updates the span state and queues the pixel this item produces, if any
        function void shade_item(span_item_t it);
            bit [7:0] lane [4];
            bit [31:0] src, hi, lo, ma;
            shade_result_t r;
            if (it.cmd == CMD_LOAD) begin
                foreach (acc[i]) begin
                    acc[i] = (it.start[i] > ACC_MAX) ? int'(ACC_MAX) : int'(it.start[i]);
                    incr[i] = int'(it.incr[i]);
                end
                loads++;
                return;
            end
            foreach (lane[i]) lane[i] = lane_byte(acc[i]);
            src = {lane[CH_ALPHA], lane[2], lane[1], lane[0]};
            if (!blend_on) begin
                r.pixel = src;
                r.wr_en = 1'b1;
                copied++;
            end else if (lane[CH_ALPHA] == 8'h00) begin
                // transparent: destination passes through, nothing written
                r.pixel = it.dest;
                r.wr_en = 1'b0;
                skipped++;
            end else begin
                ma = 32'h100 - lane[CH_ALPHA];
                hi = ((src & LANE_HI) >> 8) * lane[CH_ALPHA] + ((it.dest & LANE_HI) >> 8) * ma;
                lo = (src & LANE_LO) * lane[CH_ALPHA] + (it.dest & LANE_LO) * ma;
                r.pixel = (hi & LANE_HI) | ((lo & LANE_HI) >> 8);
                r.wr_en = 1'b1;
                blended++;
            end
            awaited_pixels.insert(awaited_pixels.size(), r);
            foreach (acc[i]) acc[i] = clamp_acc(acc[i] + incr[i]);
        endfunction

        function void check_result(t_pixel px, logic wr);
            shade_result_t want;
            if (awaited_pixels.size() == 0) begin
                $error("unexpected result: pixel_out %h write_pixel %b", px, wr);
                errors++;
                return;
            end
            want = awaited_pixels.pop_front();
            if (px !== want.pixel) begin
                $error("pixel_out mismatch: expected %h, actual %h", want.pixel, px);
                errors++;
            end
            if (wr !== want.wr_en) begin
                $error("write_pixel mismatch: expected %b, actual %b", want.wr_en, wr);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid, i_cfg_data, o_cfg_ready;
    logic i_valid, o_ready, i_cmd;
    logic [31:0] i_dest_pixel;
    logic [16:0] i_red_start, i_green_start, i_blue_start, i_alpha_start;
    logic signed [17:0] i_red_step, i_green_step, i_blue_step, i_alpha_step;
    logic o_valid, i_ready, o_write_pixel;
    logic [31:0] o_pixel_out;

    blend_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;
    int cfg_writes = 0;
    int input_stalls = 0;

    gouraud_span_alpha_blender_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_dest_pixel  (i_dest_pixel),
        .i_red_start   (i_red_start),
        .i_green_start (i_green_start),
        .i_blue_start  (i_blue_start),
        .i_alpha_start (i_alpha_start),
        .i_red_step    (i_red_step),
        .i_green_step  (i_green_step),
        .i_blue_step   (i_blue_step),
        .i_alpha_step  (i_alpha_step),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_out   (o_pixel_out),
        .o_write_pixel (o_write_pixel)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int held;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                hold_req = 1'b0;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(posedge i_clk);
                    held++;
                end
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // handshake monitor and watchdog
    always @(posedge i_clk) begin
        span_item_t seen;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_blend(i_cfg_data);
                cfg_writes++;
                moved = 1'b1;
            end
            if (i_valid && !o_ready) input_stalls++;
            if (i_valid && o_ready) begin
                seen.cmd = t_cmd'(i_cmd);
                seen.dest = i_dest_pixel;
                seen.start = '{i_red_start, i_green_start, i_blue_start, i_alpha_start};
                seen.incr = '{i_red_step, i_green_step, i_blue_step, i_alpha_step};
                sb.shade_item(seen);
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_pixel_out, o_write_pixel);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic span_item_t pixel_item(t_pixel dest);
        span_item_t it;
        it.cmd = CMD_PIXEL;
        it.dest = dest;
        foreach (it.start[i]) begin
            it.start[i] = t_acc'($urandom);
            it.incr[i] = t_step'($urandom);
        end
        return it;
    endfunction

    function automatic span_item_t uniform_load(t_acc s, t_step d);
        span_item_t it;
        it.cmd = CMD_LOAD;
        it.dest = $urandom;
        foreach (it.start[i]) begin
            it.start[i] = s;
            it.incr[i] = d;
        end
        return it;
    endfunction

    function automatic t_acc pick_start();
        case ($urandom_range(7))
            0: return '0;
            1: return ACC_MAX;
            2: return t_acc'($urandom_range(32'h10001, 32'h1ffff));
            default: return t_acc'($urandom_range(0, 32'h10000));
        endcase
    endfunction

    function automatic t_step pick_incr();
        case ($urandom_range(7))
            0: return '0;
            1: return 18'sh20000;
            2: return 18'sh1ffff;
            3: return t_step'($urandom);
            default: return t_step'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic span_item_t random_load();
        span_item_t it;
        it.cmd = CMD_LOAD;
        it.dest = $urandom;
        foreach (it.start[i]) begin
            it.start[i] = pick_start();
            it.incr[i] = pick_incr();
        end
        return it;
    endfunction

    task automatic send_item(input span_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= it.cmd;
        i_dest_pixel <= it.dest;
        i_red_start <= it.start[0];
        i_green_start <= it.start[1];
        i_blue_start <= it.start[2];
        i_alpha_start <= it.start[3];
        i_red_step <= it.incr[0];
        i_green_step <= it.incr[1];
        i_blue_step <= it.incr[2];
        i_alpha_step <= it.incr[3];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // stop offering items and let every pending pixel come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_EDGES) @(posedge i_clk);
    endtask

    task automatic write_blend(bit v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly load-then-pixels spans; some stray pixels and back-to-back loads
    task automatic run_spans(int n);
        int sent;
        int run;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1)) send_item(pixel_item($urandom));
                else send_item(random_load());
                sent++;
            end else begin
                send_item(random_load());
                run = $urandom_range(1, 12);
                repeat (run) send_item(pixel_item($urandom));
                sent += run + 1;
            end
        end
    endtask

    initial begin
        span_item_t mixed;
        int send_mix [4];
        int recv_mix [4];
        send_mix = '{0, 78, 0, 20};
        recv_mix = '{0, 0, 78, 20};
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        i_valid <= 1'b0;
        i_cmd <= CMD_LOAD;
        i_dest_pixel <= '0;
        i_red_start <= '0;
        i_green_start <= '0;
        i_blue_start <= '0;
        i_alpha_start <= '0;
        i_red_step <= '0;
        i_green_step <= '0;
        i_blue_step <= '0;
        i_alpha_step <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blend mode straight out of reset: zero alpha leaves the pixel alone
        send_item(pixel_item(32'hffffffff));
        send_item(uniform_load(ACC_MAX, '0));
        send_item(pixel_item(32'h00000000));
        send_item(pixel_item(32'hffffffff));
        // start above full scale saturates, most negative step drains to zero
        send_item(uniform_load(17'h1ffff, 18'sh20000));
        send_item(pixel_item(32'h5a5a5a5a));
        send_item(pixel_item(32'ha5a5a5a5));
        // largest positive step clamps at full intensity
        send_item(uniform_load('0, 18'sh1ffff));
        send_item(pixel_item(32'h12345678));
        send_item(pixel_item(32'h87654321));
        mixed = uniform_load('0, '0);
        mixed.start = '{17'h08000, 17'h04080, 17'h0c0c0, 17'h08080};
        mixed.incr = '{18'sh00100, -18'sh00100, 18'sh10000, -18'sh10000};
        send_item(mixed);
        send_item(pixel_item(32'hdeadbeef));
        send_item(pixel_item(32'h0f0f0f0f));
        wait_idle();
        // copy mode writes even with zero alpha
        write_blend(1'b0);
        send_item(pixel_item($urandom));
        mixed.start = '{17'h0c000, 17'h03000, 17'h0ff00, 17'h00000};
        mixed.incr = '{18'sh0, 18'sh0, 18'sh0, 18'sh0};
        send_item(mixed);
        send_item(pixel_item($urandom));
        send_item(uniform_load(ACC_MAX, '0));
        send_item(pixel_item($urandom));
        wait_idle();
        write_blend(1'b1);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_blend(p % 2 == 1);
            send_idle_pct = send_mix[p / 2];
            recv_stall_pct = recv_mix[p / 2];
            if (p == 0) begin
                run_spans(80);
                hold_req = 1'b1;
                run_spans(95);
            end else if (p == 1) begin
                run_spans(80);
                wait_idle();
                run_spans(95);
            end else begin
                run_spans(175);
            end
        end

        wait_idle();
        repeat (6) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            $error("%0d expected pixels never came out", sb.outstanding());
            sb.errors++;
        end
        $display("covered %0d span loads and %0d pixels: %0d blended, %0d copied, %0d skipped",
                 sb.loads, sb.blended + sb.copied + sb.skipped, sb.blended, sb.copied,
                 sb.skipped);
        $display("%0d blend_enable writes, %0d cycles of input back-pressure",
                 cfg_writes, input_stalls);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
